>>> src/scfr_pkg.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser package
// Command opcodes, the queued command word and the column span helper that
// are shared by the front end, the queue and the drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

package scfr_pkg;

   localparam int SPAN_W = 64;
   localparam int OUT_W = 40;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_RECT = 3'd1;
   localparam logic [2:0] OP_LINE = 3'd2;
   localparam logic [2:0] OP_TRI = 3'd3;
   localparam logic [2:0] OP_CIRCLE = 3'd4;
   localparam logic [2:0] OP_READ = 3'd5;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_CLEAR,
      KIND_DRAW,
      KIND_READ
   } kind_type;

   typedef enum logic [1:0] {
      SHAPE_SPAN,
      SHAPE_TRI,
      SHAPE_CIRCLE
   } shape_type;

   typedef struct packed {
      kind_type  kind;
      shape_type shape;
      logic [5:0] y_lo;
      logic [6:0] y_hi;
      logic [6:0] x_lo;
      logic [6:0] x_hi;
      logic [5:0] center;
      logic [5:0] radius;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ROW_RD,
      ST_ROW_WR,
      ST_READ_OUT
   } state_type;

   // Bits for columns lo..hi inclusive; empty when lo is above hi.
   function automatic logic [SPAN_W-1:0] col_span(input logic [6:0] lo, input logic [6:0] hi);
      logic [SPAN_W-1:0] lower;
      logic [SPAN_W-1:0] upper;
      lower = (lo > 7'd63) ? '0 : ({SPAN_W{1'b1}} << lo[5:0]);
      upper = (hi >= 7'd63) ? {SPAN_W{1'b1}} : ({SPAN_W{1'b1}} >> (7'd63 - hi));
      return lower & upper;
   endfunction

endpackage

`default_nettype wire

>>> src/scfr_front.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser front end
// Takes a command word, decides whether it draws, clears, reads or does
// nothing, and turns each shape into a row range and column bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_front (
   input  wire logic        start,
   input  wire logic        full,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_row,
   input  wire logic [5:0]  req_col,
   input  wire logic [5:0]  req_arg_a,
   input  wire logic [5:0]  req_arg_b,
   output logic             push,
   output scfr_pkg::cmd_type push_cmd
);

   assign push = start & ~full;

   always_comb begin
      push_cmd = '0;
      push_cmd.kind = scfr_pkg::KIND_NOP;
      push_cmd.shape = scfr_pkg::SHAPE_SPAN;
      push_cmd.y_lo = req_row;
      push_cmd.center = req_row;
      push_cmd.radius = req_arg_a;
      push_cmd.x_lo = 7'(req_col);
      case (req_op)
         scfr_pkg::OP_CLEAR: begin
            push_cmd.kind = scfr_pkg::KIND_CLEAR;
         end
         scfr_pkg::OP_RECT: begin
            if (req_arg_a != 6'd0 && req_arg_b != 6'd0) begin
               push_cmd.kind = scfr_pkg::KIND_DRAW;
               push_cmd.y_hi = 7'(req_row) + 7'(req_arg_a) - 7'd1;
               push_cmd.x_hi = 7'(req_col) + 7'(req_arg_b) - 7'd1;
            end
         end
         scfr_pkg::OP_LINE: begin
            if (req_row == req_arg_a) begin
               if (req_col <= req_arg_b) begin
                  push_cmd.kind = scfr_pkg::KIND_DRAW;
                  push_cmd.y_hi = 7'(req_row);
                  push_cmd.x_hi = 7'(req_arg_b);
               end
            end else if (req_col == req_arg_b) begin
               if (req_row <= req_arg_a) begin
                  push_cmd.kind = scfr_pkg::KIND_DRAW;
                  push_cmd.y_hi = 7'(req_arg_a);
                  push_cmd.x_hi = 7'(req_col);
               end
            end
         end
         scfr_pkg::OP_TRI: begin
            if (req_arg_a != 6'd0) begin
               push_cmd.kind = scfr_pkg::KIND_DRAW;
               push_cmd.shape = scfr_pkg::SHAPE_TRI;
               push_cmd.y_hi = 7'(req_row) + 7'(req_arg_a) - 7'd1;
            end
         end
         scfr_pkg::OP_CIRCLE: begin
            push_cmd.kind = scfr_pkg::KIND_DRAW;
            push_cmd.shape = scfr_pkg::SHAPE_CIRCLE;
            push_cmd.y_lo = 6'd0;
            push_cmd.y_hi = 7'd127;
         end
         scfr_pkg::OP_READ: begin
            push_cmd.kind = scfr_pkg::KIND_READ;
         end
         default: begin
            push_cmd.kind = scfr_pkg::KIND_NOP;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> src/scfr_queue.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser command queue
// Two-entry queue of classified commands between the front end and the
// drawing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire scfr_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output scfr_pkg::cmd_type      head_cmd,
   output scfr_pkg::q_status_type status
);

   scfr_pkg::cmd_type entry_ff [scfr_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign status.empty = (count_ff == 2'd0);
   assign status.full = (count_ff == 2'(scfr_pkg::QUEUE_DEPTH));
   assign do_push = push & ~status.full;
   assign do_pop = pop & ~status.empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

>>> src/scfr_back.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser drawing engine
// Holds the canvas memory and carries out queued commands one row at a
// time with a read-modify-write of each row word.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_back #(
   parameter int ROWS = 20,
   parameter int COLS = 40
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire scfr_pkg::q_status_type q_status,
   input  wire scfr_pkg::cmd_type      head_cmd,
   output logic                        pop,
   output logic                        rsp_strobe,
   output logic [scfr_pkg::OUT_W-1:0]  rsp_row_bits
);

   localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [6:0] LAST_ROW = 7'(ROWS - 1);

   logic [COLS-1:0] canvas_mem [ROWS];
   logic [ROWS-1:0] valid_ff;

   scfr_pkg::state_type state_ff;
   scfr_pkg::state_type state_in;
   scfr_pkg::cmd_type   cmd_ff;
   scfr_pkg::cmd_type   cmd_in;
   logic [6:0]          y_ff;
   logic [6:0]          y_in;
   logic [6:0]          y_end_ff;
   logic [6:0]          y_end_in;
   logic [11:0]         rr_ff;
   logic [11:0]         rr_in;
   logic [COLS-1:0]     mask_ff;
   logic [COLS-1:0]     mask_in;
   logic [COLS-1:0]     rd_ff;
   logic                rd_valid_ff;
   logic                rsp_strobe_ff;
   logic                rsp_strobe_in;
   logic [scfr_pkg::OUT_W-1:0] rsp_bits_ff;
   logic [scfr_pkg::OUT_W-1:0] rsp_bits_in;

   logic [RW-1:0]       rd_addr;
   logic [RW-1:0]       wr_addr;
   logic                mem_we;
   logic                clear;

   logic [6:0]          span_hi;
   logic [5:0]          dy;
   logic [11:0]         dy2;
   logic [11:0]         rem;
   logic                rem_neg;
   logic [scfr_pkg::SPAN_W-1:0] therm;
   logic [scfr_pkg::SPAN_W-1:0] therm_rev;
   logic [scfr_pkg::SPAN_W-1:0] row_mask;
   logic [scfr_pkg::SPAN_W-1:0] rd_wide;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_row_bits = rsp_bits_ff;
   assign wr_addr = y_ff[RW-1:0];
   assign rd_addr = (state_ff == scfr_pkg::ST_SETUP) ? cmd_ff.y_lo[RW-1:0] : y_ff[RW-1:0];
   assign rd_wide = scfr_pkg::SPAN_W'(rd_ff);

   always_comb begin
      span_hi = (cmd_ff.shape == scfr_pkg::SHAPE_TRI) ?
                cmd_ff.x_lo + (y_ff - 7'(cmd_ff.y_lo)) : cmd_ff.x_hi;
      dy = (y_ff[5:0] >= cmd_ff.center) ? (y_ff[5:0] - cmd_ff.center)
                                         : (cmd_ff.center - y_ff[5:0]);
      dy2 = 12'(dy) * 12'(dy);
      rem_neg = (dy2 > rr_ff);
      rem = rr_ff - dy2;
      for (int k = 0; k < scfr_pkg::SPAN_W; k++) begin
         therm[k] = ~rem_neg & (12'(k * k) <= rem);
         therm_rev[scfr_pkg::SPAN_W-1-k] = therm[k];
      end
      if (cmd_ff.shape == scfr_pkg::SHAPE_CIRCLE) begin
         row_mask = (therm << cmd_ff.x_lo[5:0]) | (therm_rev >> (6'd63 - cmd_ff.x_lo[5:0]));
      end else begin
         row_mask = scfr_pkg::col_span(cmd_ff.x_lo, span_hi);
      end
      mask_in = (state_ff == scfr_pkg::ST_ROW_RD) ? row_mask[COLS-1:0] : mask_ff;
   end

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      y_in = y_ff;
      y_end_in = y_end_ff;
      rr_in = rr_ff;
      pop = 1'b0;
      clear = 1'b0;
      mem_we = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_bits_in = '0;
      case (state_ff)
         scfr_pkg::ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               cmd_in = head_cmd;
               state_in = scfr_pkg::ST_SETUP;
            end
         end
         scfr_pkg::ST_SETUP: begin
            case (cmd_ff.kind)
               scfr_pkg::KIND_CLEAR: begin
                  clear = 1'b1;
                  rsp_strobe_in = 1'b1;
                  state_in = scfr_pkg::ST_IDLE;
               end
               scfr_pkg::KIND_READ: begin
                  if (7'(cmd_ff.y_lo) <= LAST_ROW) begin
                     state_in = scfr_pkg::ST_READ_OUT;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     state_in = scfr_pkg::ST_IDLE;
                  end
               end
               scfr_pkg::KIND_DRAW: begin
                  rr_in = 12'(cmd_ff.radius) * 12'(cmd_ff.radius);
                  y_in = 7'(cmd_ff.y_lo);
                  y_end_in = (cmd_ff.y_hi > LAST_ROW) ? LAST_ROW : cmd_ff.y_hi;
                  if (7'(cmd_ff.y_lo) > LAST_ROW || 7'(cmd_ff.y_lo) > cmd_ff.y_hi) begin
                     rsp_strobe_in = 1'b1;
                     state_in = scfr_pkg::ST_IDLE;
                  end else begin
                     state_in = scfr_pkg::ST_ROW_RD;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in = scfr_pkg::ST_IDLE;
               end
            endcase
         end
         scfr_pkg::ST_ROW_RD: begin
            state_in = scfr_pkg::ST_ROW_WR;
         end
         scfr_pkg::ST_ROW_WR: begin
            mem_we = 1'b1;
            if (y_ff == y_end_ff) begin
               rsp_strobe_in = 1'b1;
               state_in = scfr_pkg::ST_IDLE;
            end else begin
               y_in = y_ff + 7'd1;
               state_in = scfr_pkg::ST_ROW_RD;
            end
         end
         scfr_pkg::ST_READ_OUT: begin
            rsp_strobe_in = 1'b1;
            rsp_bits_in = rd_valid_ff ? rd_wide[scfr_pkg::OUT_W-1:0] : '0;
            state_in = scfr_pkg::ST_IDLE;
         end
         default: begin
            state_in = scfr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scfr_pkg::ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      y_ff <= y_in;
      y_end_ff <= y_end_in;
      rr_ff <= rr_in;
      mask_ff <= mask_in;
      rsp_bits_ff <= rsp_bits_in;
   end

   // A row that has not been written since the last clear reads as blank.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= canvas_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      if (mem_we) begin
         canvas_mem[wr_addr] <= (rd_valid_ff ? rd_ff : '0) | mask_ff;
      end
   end

endmodule

`default_nettype wire

>>> src/shape_fill_canvas_rasterizer.sv
// ----------------------------------------------------------------------------
// Shape fill canvas rasteriser
// One-bit-per-pixel canvas with clear, rectangle, line, triangle and circle
// drawing and a row read-back.
// ----------------------------------------------------------------------------
// A command is taken whenever start is high and busy is low; up to two
// commands wait in a queue while the engine works, and busy is high only
// while that queue is full. Every command yields exactly one word on
// rsp_row_bits, marked by rsp_strobe for a single cycle, in command order;
// the receiver cannot stall it. The canvas memory has one read and one
// write port, so for each canvas row a draw touches the engine passes
// through a read state and then a write state, after an idle state that
// fetches the command and a setup state that prepares it. A circle always
// sweeps every row; a read of a row on the canvas passes through a
// further output state, while clear and no-op commands answer straight
// from the setup state.
// ----------------------------------------------------------------------------
`default_nettype none

module shape_fill_canvas_rasterizer #(
   parameter int CANVAS_ROWS = 20,
   parameter int CANVAS_COLS = 40
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_row,
   input  wire logic [5:0]  req_col,
   input  wire logic [5:0]  req_arg_a,
   input  wire logic [5:0]  req_arg_b,
   output logic             rsp_strobe,
   output logic [39:0]      rsp_row_bits
);

   logic                   push;
   logic                   pop;
   scfr_pkg::cmd_type      push_cmd;
   scfr_pkg::cmd_type      head_cmd;
   scfr_pkg::q_status_type q_status;

   assign busy = q_status.full;

   scfr_front u_front (
      .start     (start),
      .full      (q_status.full),
      .req_op    (req_op),
      .req_row   (req_row),
      .req_col   (req_col),
      .req_arg_a (req_arg_a),
      .req_arg_b (req_arg_b),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   scfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status)
   );

   scfr_back #(
      .ROWS (CANVAS_ROWS),
      .COLS (CANVAS_COLS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_status     (q_status),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_row_bits (rsp_row_bits)
   );

endmodule

`default_nettype wire

>>> src/scfr_checker.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser port checker
// Tracks commands taken against words returned and checks the strobe and
// busy behaviour seen at the top level's ports.
// ----------------------------------------------------------------------------
`default_nettype none

module scfr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_strobe
);

   logic [2:0] pending_ff;
   logic [2:0] pending_in;

   assign pending_in = pending_ff + 3'(start & ~busy) - 3'(rsp_strobe);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_quiet: assert property (@(posedge clock) reset |=> !busy && !rsp_strobe)
      else $error("busy or strobe high straight after reset");

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe high on two cycles in a row");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> pending_ff != 3'd0)
      else $error("result word with no command outstanding");

   a_busy_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> pending_ff >= 3'd2)
      else $error("busy raised with fewer than two commands outstanding");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 3'd3)
      else $error("more commands outstanding than the block can hold");

endmodule

bind shape_fill_canvas_rasterizer scfr_checker u_scfr_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire

>>> tb/shape_fill_canvas_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser checker
// Watches the command and row word channels of the canvas rasteriser, keeps
// its own copy of the canvas, predicts the word for every accepted command
// and compares each strobed word with the oldest prediction.
// ----------------------------------------------------------------------------
module shape_fill_canvas_rasterizer_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [2:0]  req_op,
   input  wire logic [5:0]  req_row,
   input  wire logic [5:0]  req_col,
   input  wire logic [5:0]  req_arg_a,
   input  wire logic [5:0]  req_arg_b,
   input  wire logic        rsp_strobe,
   input  wire logic [39:0] rsp_row_bits,
   output int               fail_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS = 20;
   localparam int COLS = 40;

   logic [39:0] canvas [ROWS];
   logic [39:0] due_rows [$];
   int          mismatches = 0;
   int          outstanding = 0;

   assign fail_count = mismatches;
   assign pending = outstanding;

   function automatic logic [39:0] span_bits(input int lo, input int hi);
      logic [39:0] bits;
      bits = '0;
      for (int c = lo; c <= hi && c < COLS; c++) bits[c] = 1'b1;
      return bits;
   endfunction

   function automatic void mark_row(input int r, input logic [39:0] bits);
      if (r < ROWS) canvas[r] |= bits;
   endfunction

   function automatic void wipe_canvas();
      for (int r = 0; r < ROWS; r++) canvas[r] = '0;
   endfunction

   // Applies one command to the canvas copy and returns the word it yields.
   function automatic logic [39:0] draw_or_read(input logic [2:0] op, input int row,
                                                input int col, input int a, input int b);
      logic [39:0] word;
      int          reach;
      word = '0;
      reach = a * a;
      case (op)
         scfr_pkg::OP_CLEAR: wipe_canvas();
         scfr_pkg::OP_RECT: begin
            if (a != 0 && b != 0)
               for (int i = 0; i < a; i++) mark_row(row + i, span_bits(col, col + b - 1));
         end
         scfr_pkg::OP_LINE: begin
            if (row == a) begin
               if (col <= b) mark_row(row, span_bits(col, b));
            end else if (col == b && col < COLS) begin
               for (int i = row; i <= a; i++) mark_row(i, span_bits(col, col));
            end
         end
         scfr_pkg::OP_TRI: begin
            for (int i = 0; i < a; i++) mark_row(row + i, span_bits(col, col + i));
         end
         scfr_pkg::OP_CIRCLE: begin
            for (int y = 0; y < ROWS; y++)
               for (int x = 0; x < COLS; x++)
                  if ((x - col) * (x - col) + (y - row) * (y - row) <= reach)
                     canvas[y][x] = 1'b1;
         end
         scfr_pkg::OP_READ: begin
            if (row < ROWS) word = canvas[row];
         end
         default: ;
      endcase
      return word;
   endfunction

   always @(posedge clock) begin : watch
      logic [39:0] due_word;
      if (reset) begin
         wipe_canvas();
         due_rows.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (due_rows.size() == 0) begin
               $error("row_bits: no word expected, actual %h", rsp_row_bits);
               mismatches++;
            end else begin
               due_word = due_rows.pop_front();
               if (rsp_row_bits !== due_word) begin
                  $error("row_bits mismatch: expected %h, actual %h", due_word, rsp_row_bits);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            due_rows.push_back(draw_or_read(req_op, req_row, req_col, req_arg_a, req_arg_b));
      end
      outstanding = due_rows.size();
   end

endmodule

>>> tb/shape_fill_canvas_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// Canvas rasteriser testbench
// Drives directed and then random drawing and read-back commands in bursts
// with random gaps; the checker beside the block predicts every row word and
// reports the failures that decide the verdict.
// ----------------------------------------------------------------------------
module shape_fill_canvas_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int NUM_RANDOM = 605;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_op = '0;
   logic [5:0]  req_row = '0;
   logic [5:0]  req_col = '0;
   logic [5:0]  req_arg_a = '0;
   logic [5:0]  req_arg_b = '0;
   logic        rsp_strobe;
   logic [39:0] rsp_row_bits;
   int          fail_count;
   int          pending;

   always #5 clock = ~clock;

   shape_fill_canvas_rasterizer DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_arg_a    (req_arg_a),
      .req_arg_b    (req_arg_b),
      .rsp_strobe   (rsp_strobe),
      .rsp_row_bits (rsp_row_bits)
   );

   shape_fill_canvas_rasterizer_checker row_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_row      (req_row),
      .req_col      (req_col),
      .req_arg_a    (req_arg_a),
      .req_arg_b    (req_arg_b),
      .rsp_strobe   (rsp_strobe),
      .rsp_row_bits (rsp_row_bits),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   task automatic issue(input logic [2:0] op, input int row, input int col,
                        input int a, input int b);
      req_op <= op;
      req_row <= row[5:0];
      req_col <= col[5:0];
      req_arg_a <= a[5:0];
      req_arg_b <= b[5:0];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain();
      hold_off(1);
      while (pending != 0) @(negedge clock);
   endtask

   // Mostly values near the canvas, now and then anything the field holds.
   function automatic int pick(input int near);
      if ($urandom_range(0, 4) == 0) return $urandom_range(0, 63);
      return $urandom_range(0, near);
   endfunction

   task automatic random_command();
      int kind;
      int row;
      int col;
      int a;
      int b;
      kind = $urandom_range(0, 99);
      row = pick(22);
      col = pick(42);
      a = $urandom_range(0, 63);
      b = $urandom_range(0, 63);
      if (kind < 3) begin
         issue(scfr_pkg::OP_CLEAR, row, col, a, b);
      end else if (kind < 20) begin
         issue(scfr_pkg::OP_RECT, row, col, pick(8), pick(12));
      end else if (kind < 36) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               b = ($urandom_range(0, 3) == 0) ? pick(45) : col + $urandom_range(0, 12);
               issue(scfr_pkg::OP_LINE, row, col, row, (b > 63) ? 63 : b);
            end
            4, 5, 6, 7: issue(scfr_pkg::OP_LINE, row, col, pick(22), col);
            default: issue(scfr_pkg::OP_LINE, row, col, a, b);
         endcase
      end else if (kind < 49) begin
         issue(scfr_pkg::OP_TRI, row, col, pick(10), b);
      end else if (kind < 58) begin
         issue(scfr_pkg::OP_CIRCLE, row, col, pick(8), b);
      end else if (kind < 94) begin
         issue(scfr_pkg::OP_READ, pick(21), col, a, b);
      end else begin
         issue(($urandom_range(0, 1) == 1) ? OP_SPARE_HI : OP_SPARE_LO,
               $urandom_range(0, 63), col, a, b);
      end
   endtask

   task automatic read_back(input int first, input int last);
      for (int r = first; r <= last; r++) issue(scfr_pkg::OP_READ, r, 0, 0, 0);
   endtask

   initial begin : stimulus
      int sent;
      int burst;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(scfr_pkg::OP_READ, 0, 63, 63, 63);
      issue(scfr_pkg::OP_RECT, 0, 0, 1, 1);
      issue(scfr_pkg::OP_RECT, 2, 2, 0, 5);
      issue(scfr_pkg::OP_RECT, 2, 2, 5, 0);
      issue(scfr_pkg::OP_RECT, 63, 63, 63, 63);
      issue(scfr_pkg::OP_LINE, 3, 3, 3, 10);
      issue(scfr_pkg::OP_LINE, 30, 1, 30, 9);
      issue(scfr_pkg::OP_LINE, 4, 20, 4, 10);
      issue(scfr_pkg::OP_LINE, 2, 7, 9, 7);
      issue(scfr_pkg::OP_LINE, 1, 45, 9, 45);
      issue(scfr_pkg::OP_LINE, 9, 12, 2, 12);
      issue(scfr_pkg::OP_LINE, 5, 5, 8, 9);
      issue(scfr_pkg::OP_TRI, 10, 33, 8, 0);
      issue(scfr_pkg::OP_TRI, 6, 6, 0, 0);
      issue(scfr_pkg::OP_CIRCLE, 12, 20, 5, 0);
      issue(scfr_pkg::OP_CIRCLE, 1, 39, 0, 0);
      read_back(0, 13);
      issue(scfr_pkg::OP_READ, 20, 0, 0, 0);
      issue(scfr_pkg::OP_READ, 63, 0, 0, 0);
      issue(OP_SPARE_LO, 1, 1, 1, 1);
      issue(OP_SPARE_HI, 2, 2, 2, 2);
      issue(scfr_pkg::OP_CIRCLE, 63, 63, 63, 63);
      read_back(14, 19);
      issue(scfr_pkg::OP_RECT, 0, 0, 63, 63);
      issue(scfr_pkg::OP_READ, 19, 0, 0, 0);
      issue(scfr_pkg::OP_CLEAR, 0, 0, 0, 0);
      issue(scfr_pkg::OP_READ, 19, 0, 0, 0);
      drain();

      sent = 0;
      while (sent < NUM_RANDOM) begin
         burst = $urandom_range(1, 16);
         for (int k = 0; k < burst && sent < NUM_RANDOM; k++) begin
            random_command();
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            hold_off($urandom_range(1, ($urandom_range(0, 1) == 1) ? 6 : 60));
         if ($urandom_range(0, 39) == 0) drain();
      end

      drain();
      repeat (150) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
